// ===== rtl/sss_pkg.sv =====
`timescale 1ns / 1ps

package sss_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int LENGTH_W    = 5;
    localparam int NEEDLE_W    = 128;
    localparam int RES_OFFSET_W = 32;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_NEEDLE_LOW    = 2'd0;
    localparam t_cfg_index CFG_NEEDLE_HIGH   = 2'd1;
    localparam t_cfg_index CFG_NEEDLE_LENGTH = 2'd2;

endpackage

// ===== rtl/streaming_substring_search.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// hay       in         i_hay_valid / o_hay_ready  i_hay_byte, i_hay_last
// res       out        o_res_valid / i_res_ready  o_found, o_match_offset
// cfg       in         i_cfg_wr_en (no wait)      i_cfg_index, i_cfg_data
//
// One haystack byte is taken every cycle while o_hay_ready is high; the window
// compare and count update feed the result register, or a skid entry while the
// output stalls. A two-entry result buffer keeps bytes flowing while a result
// waits; o_hay_ready drops only when both entries are full. Reset is synchronous
// and active low and clears the needle and search state.
module streaming_substring_search #(
    parameter int MAX_NEEDLE  = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_hay_valid,
    output logic                          o_hay_ready,
    input  logic [7:0]                    i_hay_byte,
    input  logic                          i_hay_last,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic                          o_found,
    output logic [sss_pkg::RES_OFFSET_W-1:0] o_match_offset,
    input  logic                          i_cfg_wr_en,
    input  sss_pkg::t_cfg_index           i_cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sss_pkg::*;

    localparam int IDX_W = $clog2(MAX_NEEDLE);
    localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

    logic [CFG_DATA_W-1:0]             r_needle_low;
    logic [CFG_DATA_W-1:0]             r_needle_high;
    logic [LENGTH_W-1:0]               r_needle_length;

    logic [MAX_NEEDLE-1:0][7:0]        r_window;
    logic [MAX_NEEDLE-1:0][7:0]        n_window;
    logic [OFFSET_BITS-1:0]            r_seen;
    logic [OFFSET_BITS-1:0]            n_seen;
    logic                              r_done;
    logic                              n_done;

    logic                              r_out_valid;
    logic                              r_out_found;
    logic [RES_OFFSET_W-1:0]           r_out_offset;
    logic                              r_skid_valid;
    logic                              r_skid_found;
    logic [RES_OFFSET_W-1:0]           r_skid_offset;

    logic [MAX_NEEDLE-1:0][7:0]        shifted;
    logic [OFFSET_BITS-1:0]            seen_inc;
    logic [NEEDLE_W-1:0]               needle;
    logic [LEN_W-1:0]                  len;
    logic                              bytes_match;
    logic                              match;
    logic [OFFSET_BITS-1:0]            diff;
    logic                              has_result;
    logic                              res_found;
    logic [RES_OFFSET_W-1:0]           res_offset;
    logic                              accept;
    logic                              res_new;
    logic                              out_free;

    assign needle   = {r_needle_high, r_needle_low};
    assign len      = (r_needle_length > LENGTH_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE)
                                                                : LEN_W'(r_needle_length);
    assign shifted  = {r_window[MAX_NEEDLE-2:0], i_hay_byte};
    assign seen_inc = (r_seen == COUNT_MAX) ? r_seen : r_seen + OFFSET_BITS'(1);
    assign diff     = seen_inc - OFFSET_BITS'(len);

    // Needle byte i lines up with the window byte that arrived len-1-i beats ago.
    always_comb begin
        logic [LEN_W-1:0] pos;
        bytes_match = 1'b1;
        for (int i = 0; i < MAX_NEEDLE; i++) begin
            pos = len - LEN_W'(1) - LEN_W'(i);
            if (LEN_W'(i) < len) begin
                if (shifted[pos[IDX_W-1:0]] != needle[8*i +: 8]) begin
                    bytes_match = 1'b0;
                end
            end
        end
    end

    always_comb begin
        match = 1'b0;
        if (len == '0) begin
            match = 1'b1;
        end else if (seen_inc >= OFFSET_BITS'(len)) begin
            match = bytes_match;
        end
    end

    always_comb begin
        n_window   = shifted;
        n_seen     = seen_inc;
        n_done     = r_done;
        has_result = 1'b0;
        res_found  = 1'b0;
        res_offset = '0;
        if (r_done) begin
            n_window = r_window;
            n_seen   = r_seen;
            if (i_hay_last) begin
                n_seen = '0;
                n_done = 1'b0;
            end
        end else if (match) begin
            has_result = 1'b1;
            res_found  = 1'b1;
            res_offset = (len == '0) ? '0 : RES_OFFSET_W'(diff);
            if (i_hay_last) begin
                n_seen = '0;
            end else begin
                n_done = 1'b1;
            end
        end else if (i_hay_last) begin
            has_result = 1'b1;
            n_seen     = '0;
        end
    end

    assign o_hay_ready = !r_skid_valid;
    assign accept      = i_hay_valid && o_hay_ready;
    assign res_new     = accept && has_result;
    assign out_free    = !r_out_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_low    <= '0;
            r_needle_high   <= '0;
            r_needle_length <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_NEEDLE_LOW:    r_needle_low    <= i_cfg_data;
                CFG_NEEDLE_HIGH:   r_needle_high   <= i_cfg_data;
                CFG_NEEDLE_LENGTH: r_needle_length <= i_cfg_data[LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_done <= 1'b0;
        end else if (accept) begin
            r_seen <= n_seen;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_window <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_new;
            end
        end else if (res_new) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_found  <= r_skid_found;
                r_out_offset <= r_skid_offset;
            end else if (res_new) begin
                r_out_found  <= res_found;
                r_out_offset <= res_offset;
            end
        end else if (res_new) begin
            r_skid_found  <= res_found;
            r_skid_offset <= res_offset;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_match_offset = r_out_offset;

endmodule

// ===== rtl/sss_checker.sv =====
`timescale 1ns / 1ps

module sss_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_hay_valid,
    input logic                          o_hay_ready,
    input logic                          o_res_valid,
    input logic                          i_res_ready,
    input logic                          o_found,
    input logic [sss_pkg::RES_OFFSET_W-1:0] o_match_offset
);

    // A miss always reports offset zero.
    a_miss_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_found) |-> (o_match_offset == '0))
        else $error("miss reported with nonzero offset");

    // A new result beat only follows an accepted haystack byte.
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(i_hay_valid && o_hay_ready))
        else $error("result appeared without an accepted byte");

    // Input back-pressure only happens while a result is waiting.
    a_stall_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_hay_ready |-> o_res_valid)
        else $error("input stalled with no pending result");

    // A stalled result beat holds its payload.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=>
            (o_res_valid && $stable(o_found) && $stable(o_match_offset)))
        else $error("result beat changed while stalled");

endmodule

bind streaming_substring_search sss_checker u_sss_checker (.*);
